@@ design/hvt_pkg.sv @@
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types and constants for the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int ElemW    = 32;
  localparam int FracBits = 16;
  localparam int OutW     = 32;
  localparam int NumRegs  = 8;
  localparam int RegIdxW  = 3;
  localparam int CfgIdxW  = 4;
  localparam int CfgW     = 64;
  localparam int NumCols  = 4;
  localparam int ProdW    = 2 * ElemW;
  localparam int SumW     = ProdW + 2 - FracBits;
  // quotient bits of floor(|num| * 2^(F+1) / |den|) when not saturated
  localparam int QW       = OutW + 1;
  localparam int SatShift = OutW - 1 - FracBits;
  localparam int DivLat   = QW + 3;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [OutW-1:0]  res_t;

  localparam elem_t OneFix = elem_t'(1) <<< FracBits;

  localparam logic [CfgW-1:0] RegReset [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic              mode;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] vec_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               divide_by_zero;
    logic               saturated;
  } out_item_t;

endpackage

@@ design/hvt_dot_lane.sv @@
// ----------------------------------------------------------------------------
// hvt_dot_lane
// One matrix row times the vertex: four products, adder tree, round half up.
// ----------------------------------------------------------------------------
module hvt_dot_lane (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  hvt_pkg::elem_t [hvt_pkg::NumCols-1:0] row_i,
  input  hvt_pkg::elem_t [hvt_pkg::NumCols-1:0] vec_i,
  output hvt_pkg::sum_t                    sum_o
);
  import hvt_pkg::*;

  logic signed [ProdW-1:0] prod_q [NumCols];
  logic signed [ProdW:0]   s01_q, s23_q;
  logic signed [ProdW+1:0] tot;
  sum_t                    sum_q;

  localparam logic signed [ProdW+1:0] RoundBias = (ProdW+2)'(1) <<< (FracBits - 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < NumCols; c++) begin
        prod_q[c] <= $signed(row_i[c]) * $signed(vec_i[c]);
      end
      s01_q <= (ProdW+1)'(prod_q[0]) + (ProdW+1)'(prod_q[1]);
      s23_q <= (ProdW+1)'(prod_q[2]) + (ProdW+1)'(prod_q[3]);
      sum_q <= tot[ProdW+1:FracBits];
    end
  end

  assign tot   = (ProdW+2)'(s01_q) + (ProdW+2)'(s23_q) + RoundBias;
  assign sum_o = sum_q;

endmodule

@@ design/hvt_div_lane.sv @@
// ----------------------------------------------------------------------------
// hvt_div_lane
// Pipelined restoring divider for the perspective divide, one quotient bit
// per stage, rounded to nearest on the magnitude and saturated to 32 bits.
// ----------------------------------------------------------------------------
module hvt_div_lane (
  input  logic          clk_i,
  input  logic          en_i,
  input  hvt_pkg::sum_t num_i,
  input  hvt_pkg::sum_t den_i,
  output hvt_pkg::res_t res_o,
  output logic          sat_o
);
  import hvt_pkg::*;

  localparam int CmpW  = SumW + SatShift + 1;
  localparam int LowW  = QW - FracBits - 1;

  logic [SumW-1:0] a_an_q, a_ad_q;
  logic            a_neg_q;
  logic [CmpW-1:0] ovf_lim;

  logic [SumW-1:0] r_q   [QW+1];
  logic [QW-1:0]   n_q   [QW+1];
  logic [QW-1:0]   q_q   [QW+1];
  logic [SumW-1:0] ad_q  [QW+1];
  logic            neg_q [QW+1];
  logic            sat_q [QW+1];

  logic [QW:0]     mag_full;
  logic [QW:0]     limit;
  logic [QW:0]     mag;
  res_t            res_q;
  logic            sato_q;

  assign ovf_lim = (CmpW'(a_ad_q) << SatShift) + CmpW'(a_ad_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // take magnitudes and the result sign
      a_an_q  <= num_i[SumW-1] ? SumW'(~num_i + 1'b1) : SumW'(num_i);
      a_ad_q  <= den_i[SumW-1] ? SumW'(~den_i + 1'b1) : SumW'(den_i);
      a_neg_q <= num_i[SumW-1] ^ den_i[SumW-1];
      // integer part above range saturates; else seed the remainder
      r_q[0]   <= SumW'(a_an_q >> LowW);
      n_q[0]   <= {a_an_q[LowW-1:0], (FracBits+1)'(0)};
      q_q[0]   <= '0;
      ad_q[0]  <= a_ad_q;
      neg_q[0] <= a_neg_q;
      sat_q[0] <= CmpW'(a_an_q) >= ovf_lim;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [SumW:0] trial;
    logic          take;
    assign trial = {r_q[k-1], n_q[k-1][QW-1]};
    assign take  = trial >= {1'b0, ad_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= take ? SumW'(trial - {1'b0, ad_q[k-1]}) : SumW'(trial);
        n_q[k]   <= n_q[k-1] << 1;
        q_q[k]   <= {q_q[k-1][QW-2:0], take};
        ad_q[k]  <= ad_q[k-1];
        neg_q[k] <= neg_q[k-1];
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  always_comb begin
    mag_full = ({1'b0, q_q[QW]} + (QW+1)'(1)) >> 1;
    limit    = neg_q[QW] ? ((QW+1)'(1) << (OutW - 1)) : (((QW+1)'(1) << (OutW - 1)) - 1'b1);
    mag      = (sat_q[QW] || mag_full > limit) ? limit : mag_full;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= neg_q[QW] ? OutW'(~mag + 1'b1) : OutW'(mag);
      sato_q <= sat_q[QW] || mag_full > limit;
    end
  end

  assign res_o = res_q;
  assign sat_o = sato_q;

endmodule

@@ design/homogeneous_vertex_transform_top.sv @@
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_top
// 4x4 Q16.16 matrix times vertex, with optional perspective divide.
//
//   channel  | signals                                  | direction
//   input    | in_valid_i, in_ready_o, in_data_i        | item in
//   output   | out_valid_o, out_ready_i, out_data_o     | item out
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i          | register write
//
// One item per cycle while the output is not stalled; the depth is set by
// the 33-stage restoring divider in each of the three divide lanes.
// The whole pipeline advances when the output register is empty or taken,
// so a stall on the output holds every stage. Reset loads the identity
// matrix and clears all valid bits.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hvt_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hvt_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [hvt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [hvt_pkg::CfgW-1:0]          cfg_data_i
);
  import hvt_pkg::*;

  localparam int PipeLen = 1 + 3 + DivLat;
  localparam sum_t MaxPos = sum_t'(64'sd2147483647);
  localparam sum_t MinNeg = sum_t'(-64'sd2147483648);

  typedef struct packed {
    logic sat;
    res_t val;
  } clamp_t;

  typedef struct packed {
    logic mode;
    logic dz;
    logic sat;
    res_t x;
    res_t y;
    res_t z;
    res_t w;
  } side_t;

  function automatic clamp_t clamp32(sum_t v);
    clamp_t c;
    c.sat = 1'b0;
    c.val = OutW'(v);
    if (v > MaxPos) begin
      c.sat = 1'b1;
      c.val = OutW'(MaxPos);
    end else if (v < MinNeg) begin
      c.sat = 1'b1;
      c.val = OutW'(MinNeg);
    end
    return c;
  endfunction

  logic [CfgW-1:0]       mat_q [NumRegs];
  logic                  adv;
  logic [PipeLen-1:0]    vld_q;
  logic [3:0]            mode_q;
  elem_t [NumCols-1:0]   vec_q;
  elem_t [NumCols-1:0]   row [4];
  sum_t                  sum [4];
  res_t                  dres [3];
  logic                  dsat [3];
  clamp_t                cl [4];
  side_t                 side_d;
  side_t                 side_q [DivLat];
  side_t                 so;
  logic                  out_valid_q;
  out_item_t             out_q;

  assign adv        = ~out_valid_q | out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) mat_q[i] <= RegReset[i];
    end else if (cfg_we_i && cfg_idx_i < CfgIdxW'(NumRegs)) begin
      mat_q[cfg_idx_i[RegIdxW-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[PipeLen-2:0], in_valid_i};
      out_valid_q <= vld_q[PipeLen-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vec_q[0] <= in_data_i.vec_x;
      vec_q[1] <= in_data_i.vec_y;
      vec_q[2] <= in_data_i.vec_z;
      vec_q[3] <= in_data_i.mode ? OneFix : in_data_i.vec_w;
      mode_q   <= {mode_q[2:0], in_data_i.mode};
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < NumCols; c++) begin : g_col
      assign row[r][c] = mat_q[2*r + c/2][32*(c%2) +: ElemW];
    end
    hvt_dot_lane u_dot (
      .clk_i (clk_i),
      .en_i  (adv),
      .row_i (row[r]),
      .vec_i (vec_q),
      .sum_o (sum[r])
    );
    assign cl[r] = clamp32(sum[r]);
  end

  for (genvar r = 0; r < 3; r++) begin : g_div
    hvt_div_lane u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (sum[r]),
      .den_i (sum[3]),
      .res_o (dres[r]),
      .sat_o (dsat[r])
    );
  end

  always_comb begin
    side_d.mode = mode_q[3];
    side_d.dz   = mode_q[3] & (sum[3] == '0);
    side_d.sat  = cl[3].sat | (~mode_q[3] & (cl[0].sat | cl[1].sat | cl[2].sat));
    side_d.x    = cl[0].val;
    side_d.y    = cl[1].val;
    side_d.z    = cl[2].val;
    side_d.w    = cl[3].val;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int i = 1; i < DivLat; i++) side_q[i] <= side_q[i-1];
    end
  end

  assign so = side_q[DivLat-1];

  // merge: pick clamped sums, the quotients, or zeros on a zero divisor
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_w          <= so.w;
      out_q.divide_by_zero <= so.dz;
      out_q.saturated      <= so.sat | (so.mode & ~so.dz & (dsat[0] | dsat[1] | dsat[2]));
      if (!so.mode) begin
        out_q.out_x <= so.x;
        out_q.out_y <= so.y;
        out_q.out_z <= so.z;
      end else if (so.dz) begin
        out_q.out_x <= '0;
        out_q.out_y <= '0;
        out_q.out_z <= '0;
      end else begin
        out_q.out_x <= dres[0];
        out_q.out_y <= dres[1];
        out_q.out_z <= dres[2];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
